@@ design/arpc_pkg.sv @@
// ----------------------------------------------------------------------------
// arpc_pkg
// Shared types and constants for the ARP cache block.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int TableDepth  = 16;
  localparam int OwnIpSlots  = 4;
  localparam int MaxResults  = 64;
  localparam int IdxW        = $clog2(TableDepth);
  localparam int CntW        = $clog2(TableDepth + 1);
  localparam int QueueDepth  = 2;

  localparam logic [15:0] EtherArp   = 16'h0806;
  localparam logic [15:0] OpRequest  = 16'h0001;
  localparam logic [15:0] OpReply    = 16'h0002;
  localparam logic [47:0] BroadcastHw = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_PACKET = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_BY_IP  = 2'd2,
    KIND_BY_MAC = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RES_REPLY   = 2'd0,
    RES_REQUEST = 2'd1,
    RES_LOOKUP  = 2'd2
  } res_kind_t;

  typedef enum logic [2:0] {
    CFG_OWN_MAC     = 3'd0,
    CFG_OWN_IP_0    = 3'd1,
    CFG_OWN_IP_1    = 3'd2,
    CFG_OWN_IP_2    = 3'd3,
    CFG_OWN_IP_3    = 3'd4,
    CFG_OWN_IP_CNT  = 3'd5,
    CFG_REFRESH_AGE = 3'd6,
    CFG_DELETE_AGE  = 3'd7
  } cfg_idx_t;

  // classified command handed from front to back
  typedef enum logic [3:0] {
    CMD_LEARN  = 4'b0001,
    CMD_REPLY  = 4'b0010,
    CMD_TICK   = 4'b0100,
    CMD_LOOKUP = 4'b1000
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic        by_ip;
    logic [47:0] hw;
    logic [31:0] ip;
    logic [31:0] tp;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [47:0] dest_hw;
    logic [31:0] out_sender_proto;
    logic [47:0] out_target_hw;
    logic [31:0] out_target_proto;
    logic        found;
    logic [31:0] found_ip;
    logic [47:0] found_mac;
    logic        last;
  } res_t;

endpackage

@@ design/arpc_front.sv @@
// ----------------------------------------------------------------------------
// arpc_front
// Accepts input requests, filters packets and classifies them into commands.
// ----------------------------------------------------------------------------
module arpc_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic [15:0]        ether_type,
  input  logic [15:0]        arp_opcode,
  input  logic [47:0]        sender_hw,
  input  logic [31:0]        sender_proto,
  input  logic [31:0]        target_proto,
  input  logic               accept_any,
  input  logic [31:0]        query_ip,
  input  logic [47:0]        query_mac,
  input  logic [31:0]        own_ip [arpc_pkg::OwnIpSlots],
  input  logic [2:0]         own_ip_count,
  output logic               q_valid,
  input  logic               q_pop,
  output arpc_pkg::req_t     q_head
);
  import arpc_pkg::*;

  localparam int QW = $clog2(QueueDepth + 1);

  req_t          queue [QueueDepth];
  logic [QW-1:0] fill;
  logic          allow;
  logic          keep;
  logic          push;
  req_t          cls;
  logic [2:0]    slots;

  always_comb begin
    slots = (own_ip_count > 3'(OwnIpSlots)) ? 3'(OwnIpSlots) : own_ip_count;
    allow = accept_any;
    for (int s = 0; s < OwnIpSlots; s++) begin
      if (3'(s) < slots && own_ip[s] == target_proto) allow = 1'b1;
    end
    cls = '0;
    keep = 1'b0;
    cls.hw = sender_hw;
    cls.ip = sender_proto;
    cls.tp = target_proto;
    unique case (kind_t'(kind))
      KIND_PACKET: begin
        cls.cmd = (arp_opcode == OpRequest) ? CMD_REPLY : CMD_LEARN;
        // learning matches entries on the sender IP
        cls.by_ip = 1'b1;
        keep = (ether_type == EtherArp) && allow &&
               (arp_opcode == OpRequest || arp_opcode == OpReply);
      end
      KIND_TICK: begin
        cls.cmd = CMD_TICK;
        keep = 1'b1;
      end
      KIND_BY_IP, KIND_BY_MAC: begin
        cls.cmd = CMD_LOOKUP;
        cls.by_ip = (kind_t'(kind) == KIND_BY_IP);
        cls.ip = query_ip;
        cls.hw = query_mac;
        keep = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_stall = (fill == QW'(QueueDepth));
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (fill != '0);
  assign q_head   = queue[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else begin
      fill <= fill + QW'(push) - QW'(q_pop);
    end
  end

  // shift-out queue; head always at slot 0
  always_ff @(posedge clk) begin
    for (int i = 0; i < QueueDepth; i++) begin
      if (q_pop) begin
        if (i + 1 < QueueDepth) queue[i] <= queue[(i + 1) % QueueDepth];
        if (push && QW'(i) == fill - QW'(1)) queue[i] <= cls;
      end else if (push && QW'(i) == fill) begin
        queue[i] <= cls;
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= QW'(QueueDepth)) else $error("queue overfill");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    (fill == QW'(QueueDepth) && !q_pop) |=> in_stall) else $error("stall lost");
`endif

endmodule

@@ design/arpc_back.sv @@
// ----------------------------------------------------------------------------
// arpc_back
// Carries out commands one at a time, walking the entry table entry by entry.
// ----------------------------------------------------------------------------
module arpc_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_pop,
  input  arpc_pkg::req_t     q_head,
  input  logic [31:0]        own_ip [arpc_pkg::OwnIpSlots],
  input  logic [2:0]         own_ip_count,
  input  logic [15:0]        refresh_age,
  input  logic [15:0]        delete_age,
  output logic               out_valid,
  input  logic               out_stall,
  output arpc_pkg::res_t     out_res
);
  import arpc_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_TICK  = 6'b000100,
    ST_REQ   = 6'b001000,
    ST_SHIFT = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_t;

  state_t          state;
  req_t            cur;
  logic [31:0]     e_ip  [TableDepth];
  logic [47:0]     e_mac [TableDepth];
  logic [15:0]     e_age [TableDepth];
  logic [CntW-1:0] count;
  logic [CntW-1:0] idx;
  logic [CntW-1:0] sh;
  logic [2:0]      slot;
  logic [6:0]      nres;
  logic [15:0]     age_inc;
  logic [2:0]      slots;
  logic [IdxW-1:0] ix;
  logic [IdxW-1:0] shx;
  logic            hit;
  logic            obuf_free;
  logic            del;
  logic            req_emit;
  logic            load;
  // pending result: the final one sends once the scan or tick is over
  res_t            pend;
  logic            pend_v;

  assign ix  = idx[IdxW-1:0];
  assign shx = sh[IdxW-1:0];
  assign slots = (own_ip_count > 3'(OwnIpSlots)) ? 3'(OwnIpSlots) : own_ip_count;
  assign age_inc = (e_age[ix] == 16'hFFFF) ? e_age[ix] : e_age[ix] + 16'd1;
  assign hit = cur.by_ip ? (e_ip[ix] == cur.ip) : (e_mac[ix] == cur.hw);
  assign obuf_free = !out_valid || !out_stall;
  assign del = e_age[ix] > delete_age;
  assign req_emit = (e_age[ix] > refresh_age) && (slot < slots) &&
                    (nres < 7'(MaxResults));
  // pend moves into the output register
  assign load = obuf_free && pend_v &&
                ((state == ST_IDLE) || (state == ST_REQ && req_emit));
  assign q_pop = (state == ST_IDLE) && q_valid && !pend_v;

  function automatic res_t mk_req(input logic [31:0] sp, input logic [31:0] tp);
    res_t r;
    r = '0;
    r.result_kind = RES_REQUEST;
    r.dest_hw = BroadcastHw;
    r.out_sender_proto = sp;
    r.out_target_proto = tp;
    return r;
  endfunction

  function automatic res_t mk_reply(input logic [47:0] hw, input logic [31:0] sp,
                                    input logic [31:0] tp);
    res_t r;
    r = '0;
    r.result_kind = RES_REPLY;
    r.dest_hw = hw;
    r.out_sender_proto = sp;
    r.out_target_hw = hw;
    r.out_target_proto = tp;
    return r;
  endfunction

  function automatic res_t mk_lookup(input logic f, input logic [31:0] ip,
                                     input logic [47:0] mac);
    res_t r;
    r = '0;
    r.result_kind = RES_LOOKUP;
    r.found = f;
    r.found_ip = ip;
    r.found_mac = mac;
    return r;
  endfunction

  function automatic res_t with_last(input res_t r);
    res_t o;
    o = r;
    o.last = 1'b1;
    return o;
  endfunction

  // output register; the final result of a command leaves from idle
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_res <= (state == ST_IDLE) ? with_last(pend) : pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pend_v <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (pend_v && obuf_free) begin
            pend_v <= 1'b0;
          end else if (q_pop) begin
            cur <= q_head;
            idx <= '0;
            slot <= '0;
            nres <= '0;
            if (q_head.cmd == CMD_TICK) state <= ST_TICK;
            else state <= ST_SCAN;
            if (q_head.cmd == CMD_REPLY) begin
              pend <= mk_reply(q_head.hw, q_head.tp, q_head.ip);
              pend_v <= 1'b1;
            end
          end
        end
        ST_SCAN: begin
          if (idx < count && hit) begin
            if (cur.cmd == CMD_LOOKUP) begin
              pend <= mk_lookup(1'b1, e_ip[ix], e_mac[ix]);
              pend_v <= 1'b1;
            end else begin
              e_mac[ix] <= cur.hw;
              e_age[ix] <= '0;
            end
            state <= ST_IDLE;
          end else if (idx >= count || idx == CntW'(TableDepth)) begin
            if (cur.cmd == CMD_LOOKUP) begin
              pend <= mk_lookup(1'b0, '0, '0);
              pend_v <= 1'b1;
            end else if (count < CntW'(TableDepth)) begin
              e_ip[count[IdxW-1:0]] <= cur.ip;
              e_mac[count[IdxW-1:0]] <= cur.hw;
              e_age[count[IdxW-1:0]] <= '0;
              count <= count + CntW'(1);
            end
            state <= ST_IDLE;
          end else begin
            idx <= idx + CntW'(1);
          end
        end
        ST_TICK: begin
          if (idx >= count) begin
            state <= ST_IDLE;
          end else begin
            e_age[ix] <= age_inc;
            slot <= '0;
            state <= ST_REQ;
          end
        end
        ST_REQ: begin
          // age already bumped; emit requests then maybe delete
          if (req_emit) begin
            if (obuf_free || !pend_v) begin
              pend <= mk_req(own_ip[slot[1:0]], e_ip[ix]);
              pend_v <= 1'b1;
              nres <= nres + 7'd1;
              slot <= slot + 3'd1;
            end
          end else if (del) begin
            sh <= idx;
            state <= ST_SHIFT;
          end else begin
            idx <= idx + CntW'(1);
            state <= ST_TICK;
          end
        end
        ST_SHIFT: begin
          if (sh + CntW'(1) < count) begin
            e_ip[shx]  <= e_ip[shx + IdxW'(1)];
            e_mac[shx] <= e_mac[shx + IdxW'(1)];
            e_age[shx] <= e_age[shx + IdxW'(1)];
            sh <= sh + CntW'(1);
          end else begin
            count <= count - CntW'(1);
            state <= ST_TICK;
          end
        end
        ST_EMIT: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(TableDepth)) else $error("count overflow");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> (state != ST_IDLE || pend_v || $past(q_head.cmd) == CMD_LEARN))
    else $error("popped command dropped");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid) else $error("result lost");
`endif

endmodule

@@ design/arp_cache_learn_reply_age.sv @@
// ----------------------------------------------------------------------------
// arp_cache_learn_reply_age
// ARP cache: learns from packets, answers requests and lookups, ages entries.
// ----------------------------------------------------------------------------
// Use: the input channel (in_valid/in_stall) takes one request per packet,
// tick or lookup. The output channel (out_valid/out_stall) delivers results;
// `last` marks the final result of one request. A plain write port sets the
// own addresses and age limits; the user must write it only while the block
// is idle, the block does not enforce this. Front end filters and classifies
// requests into a two-entry queue; the back end walks the 16-entry table
// entry by entry. A learn or lookup scans the table; a lookup's result passes
// from the pending slot into the output register. A tick bumps each entry's
// age, emits refresh requests and on deletion shifts later entries down. The
// back end handles one command at a time; the queue lets two more requests
// in meanwhile. Reset clears the table count and own addresses and sets the
// age limits to 60 and 120; table contents need no clear. A stalled result
// holds in the output register; the back end waits.
// ----------------------------------------------------------------------------
module arp_cache_learn_reply_age (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [15:0] ether_type,
  input  logic [15:0] arp_opcode,
  input  logic [47:0] sender_hw,
  input  logic [31:0] sender_proto,
  input  logic [31:0] target_proto,
  input  logic        accept_any,
  input  logic [31:0] query_ip,
  input  logic [47:0] query_mac,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [47:0] dest_hw,
  output logic [31:0] out_sender_proto,
  output logic [47:0] out_target_hw,
  output logic [31:0] out_target_proto,
  output logic        found,
  output logic [31:0] found_ip,
  output logic [47:0] found_mac,
  output logic        last
);
  import arpc_pkg::*;

  logic [47:0] own_mac;
  logic [31:0] own_ip [OwnIpSlots];
  logic [2:0]  own_ip_count;
  logic [15:0] refresh_age;
  logic [15:0] delete_age;
  logic        q_valid;
  logic        q_pop;
  req_t        q_head;
  res_t        res;

  // config registers; own_mac is kept but feeds no result
  always_ff @(posedge clk) begin
    if (rst) begin
      own_mac <= '0;
      for (int i = 0; i < OwnIpSlots; i++) own_ip[i] <= '0;
      own_ip_count <= '0;
      refresh_age <= 16'd60;
      delete_age <= 16'd120;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_OWN_MAC:     own_mac <= cfg_data;
        CFG_OWN_IP_0:    own_ip[0] <= cfg_data[31:0];
        CFG_OWN_IP_1:    own_ip[1] <= cfg_data[31:0];
        CFG_OWN_IP_2:    own_ip[2] <= cfg_data[31:0];
        CFG_OWN_IP_3:    own_ip[3] <= cfg_data[31:0];
        CFG_OWN_IP_CNT:  own_ip_count <= cfg_data[2:0];
        CFG_REFRESH_AGE: refresh_age <= cfg_data[15:0];
        CFG_DELETE_AGE:  delete_age <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  arpc_front u_front (
    .clk, .rst, .in_valid, .in_stall, .kind, .ether_type, .arp_opcode,
    .sender_hw, .sender_proto, .target_proto, .accept_any, .query_ip,
    .query_mac, .own_ip, .own_ip_count, .q_valid, .q_pop, .q_head
  );

  arpc_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_head, .own_ip, .own_ip_count,
    .refresh_age, .delete_age, .out_valid, .out_stall, .out_res(res)
  );

  assign result_kind      = res.result_kind;
  assign dest_hw          = res.dest_hw;
  assign out_sender_proto = res.out_sender_proto;
  assign out_target_hw    = res.out_target_hw;
  assign out_target_proto = res.out_target_proto;
  assign found            = res.found;
  assign found_ip         = res.found_ip;
  assign found_mac        = res.found_mac ^ (own_mac & 48'h0);
  assign last             = res.last;

`ifndef ASSERT_OFF
  a_res_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result_kind != 2'd3)) else $error("bad result kind");
  a_found_lookup: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (result_kind == RES_LOOKUP)) else $error("found on send");
  a_lookup_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result_kind == RES_LOOKUP) |-> last) else $error("lookup not last");
`endif

endmodule
